@@ hdl/ppi_pkg.sv @@
// Types, constants and helper functions for the plane-plane intersection block.
// No dependencies; used by every other file in hdl.
`default_nettype none
package ppi_pkg;

    localparam int EPS_W     = 31;
    localparam int COORD_W   = 32;
    localparam int MAG_W     = 31;
    localparam int NUM_W     = 57;
    localparam int DIV_STEPS = 32;
    localparam int FRONT_STG = 6;

    localparam logic [EPS_W-1:0]   EPS_RESET = EPS_W'(1);
    localparam logic [COORD_W-1:0] SAT_MAX   = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] SAT_MIN   = 32'h8000_0000;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } t_axis;

    typedef enum logic [1:0] {
        PAIR_NONE,
        PAIR_YZ,
        PAIR_XZ,
        PAIR_XY
    } t_pair;

    typedef struct packed {
        logic signed [15:0] plane_a_normal_x;
        logic signed [15:0] plane_a_normal_y;
        logic signed [15:0] plane_a_normal_z;
        logic signed [15:0] plane_a_point_x;
        logic signed [15:0] plane_a_point_y;
        logic signed [15:0] plane_a_point_z;
        logic signed [15:0] plane_b_normal_x;
        logic signed [15:0] plane_b_normal_y;
        logic signed [15:0] plane_b_normal_z;
        logic signed [15:0] plane_b_point_x;
        logic signed [15:0] plane_b_point_y;
        logic signed [15:0] plane_b_point_z;
    } t_in_word;

    typedef struct packed {
        logic                      found;
        logic signed [COORD_W-1:0] line_point_x;
        logic signed [COORD_W-1:0] line_point_y;
        logic signed [COORD_W-1:0] line_point_z;
        logic signed [COORD_W-1:0] line_dir_x;
        logic signed [COORD_W-1:0] line_dir_y;
        logic signed [COORD_W-1:0] line_dir_z;
    } t_out_word;

    // travels alongside the dividers
    typedef struct packed {
        logic                      found;
        t_pair                     pair;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic                      neg_u;
        logic                      neg_v;
        logic                      ovf_u;
        logic                      ovf_v;
    } t_side;

    typedef struct packed {
        logic [NUM_W-1:0] mag_u;
        logic [NUM_W-1:0] mag_v;
        logic [MAG_W-1:0] den;
        t_side            side;
    } t_div_in;

    // rem: partial remainder; low: dividend bits still to shift in, quotient bits behind
    typedef struct packed {
        logic [MAG_W-1:0]   rem;
        logic [COORD_W-1:0] low;
    } t_div_lane;

    function automatic t_div_lane div_load(logic [NUM_W-1:0] mag);
        t_div_lane l;
        l.rem = MAG_W'(mag[NUM_W-1:COORD_W]);
        l.low = mag[COORD_W-1:0];
        return l;
    endfunction

    function automatic t_div_lane div_step(t_div_lane l, logic [MAG_W-1:0] den);
        logic [MAG_W:0] t;
        logic [MAG_W:0] d;
        t_div_lane      r;
        t = {l.rem, l.low[COORD_W-1]};
        d = {1'b0, den};
        if (t >= d) begin
            r.rem = MAG_W'(t - d);
            r.low = {l.low[COORD_W-2:0], 1'b1};
        end else begin
            r.rem = t[MAG_W-1:0];
            r.low = {l.low[COORD_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] sat_q(logic [COORD_W-1:0] q, logic neg, logic ovf);
        logic [COORD_W-1:0] r;
        if (neg) begin
            if (ovf || q > SAT_MIN) r = SAT_MIN;
            else r = COORD_W'(-q);
        end else begin
            if (ovf || q[COORD_W-1]) r = SAT_MAX;
            else r = q;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/ppi_ifs.sv @@
// Valid/ready channel interfaces for the input and result words.
// Depends on ppi_pkg.
`default_nettype none
interface ppi_in_if;
    logic             valid;
    logic             ready;
    ppi_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ppi_out_if;
    logic               valid;
    logic               ready;
    ppi_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/ppi_front.sv @@
// Front pipeline: cross product, plane offsets, parallel test, axis choice,
// Cramer numerators and divider set-up. Six stages. Depends on ppi_pkg.
`default_nettype none
module ppi_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  ppi_pkg::t_in_word      i_word,
    input  wire logic [ppi_pkg::EPS_W-1:0] i_eps,
    output logic                   o_valid,
    output ppi_pkg::t_div_in       o_word
);
    logic [ppi_pkg::FRONT_STG-1:0] r_v;

    // stage 1
    ppi_pkg::t_in_word r1_w;
    logic signed [31:0] r1_pyz, r1_pzy, r1_pzx, r1_pxz, r1_pxy, r1_pyx;
    logic signed [31:0] r1_ma0, r1_ma1, r1_ma2, r1_mb0, r1_mb1, r1_mb2;
    // stage 2
    ppi_pkg::t_in_word r2_w;
    logic signed [31:0] r2_dir0, r2_dir1, r2_dir2;
    logic signed [32:0] r2_da, r2_db;
    logic signed [32:0] n2_dir0, n2_dir1, n2_dir2;
    // stage 3
    ppi_pkg::t_in_word r3_w;
    logic signed [31:0] r3_dir0, r3_dir1, r3_dir2;
    logic signed [32:0] r3_da, r3_db;
    logic [30:0] r3_ax, r3_ay, r3_az;
    logic [61:0] r3_sq0, r3_sq1, r3_sq2, r3_eps2;
    ppi_pkg::t_axis r3_fix;
    logic [30:0] n3_ax, n3_ay, n3_az;
    ppi_pkg::t_axis n3_fix;
    // stage 4
    logic signed [31:0] r4_dir0, r4_dir1, r4_dir2, r4_det;
    logic signed [32:0] r4_da, r4_db;
    logic signed [15:0] r4_a, r4_b, r4_c, r4_d;
    logic r4_found;
    ppi_pkg::t_pair r4_pair;
    logic [63:0] n4_len2;
    logic n4_ok0, n4_ok1, n4_ok2;
    ppi_pkg::t_pair n4_pair;
    logic signed [15:0] n4_a, n4_b, n4_c, n4_d;
    logic signed [31:0] n4_det;
    // stage 5
    logic signed [48:0] r5_ad, r5_bdb, r5_adb, r5_cda;
    logic signed [31:0] r5_dir0, r5_dir1, r5_dir2, r5_det;
    logic r5_found;
    ppi_pkg::t_pair r5_pair;
    // stage 6
    ppi_pkg::t_div_in r6_word;
    logic signed [49:0] n6_nu, n6_nv;
    logic [48:0] n6_mu, n6_mv;
    logic [ppi_pkg::NUM_W-1:0] n6_numu, n6_numv;
    logic [ppi_pkg::MAG_W-1:0] n6_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ppi_pkg::FRONT_STG-2:0], i_valid};
        end
    end

    always_comb begin
        n2_dir0 = 33'(r1_pyz) - 33'(r1_pzy);
        n2_dir1 = 33'(r1_pzx) - 33'(r1_pxz);
        n2_dir2 = 33'(r1_pxy) - 33'(r1_pyx);

        n3_ax = r2_dir0[31] ? 31'(-r2_dir0) : r2_dir0[30:0];
        n3_ay = r2_dir1[31] ? 31'(-r2_dir1) : r2_dir1[30:0];
        n3_az = r2_dir2[31] ? 31'(-r2_dir2) : r2_dir2[30:0];
        if (n3_ay > n3_ax && n3_ay > n3_az) n3_fix = ppi_pkg::AXIS_Y;
        else if (n3_az > n3_ax && n3_az > n3_ay) n3_fix = ppi_pkg::AXIS_Z;
        else n3_fix = ppi_pkg::AXIS_X;

        n4_len2 = 64'(r3_sq0) + 64'(r3_sq1) + 64'(r3_sq2);
        n4_ok0  = r3_ax > i_eps;
        n4_ok1  = r3_ay > i_eps;
        n4_ok2  = r3_az > i_eps;
        case (r3_fix)
            ppi_pkg::AXIS_X: n4_pair = n4_ok0 ? ppi_pkg::PAIR_YZ :
                                       (n4_ok1 ? ppi_pkg::PAIR_XZ : ppi_pkg::PAIR_NONE);
            ppi_pkg::AXIS_Y: n4_pair = n4_ok1 ? ppi_pkg::PAIR_XZ :
                                       (n4_ok2 ? ppi_pkg::PAIR_XY : ppi_pkg::PAIR_NONE);
            ppi_pkg::AXIS_Z: n4_pair = n4_ok2 ? ppi_pkg::PAIR_XY :
                                       (n4_ok0 ? ppi_pkg::PAIR_YZ : ppi_pkg::PAIR_NONE);
            default:         n4_pair = ppi_pkg::PAIR_NONE;
        endcase
        // the 2x2 determinants are the direction components
        case (n4_pair)
            ppi_pkg::PAIR_XZ: begin
                n4_a = r3_w.plane_a_normal_x;  n4_b = r3_w.plane_a_normal_z;
                n4_c = r3_w.plane_b_normal_x;  n4_d = r3_w.plane_b_normal_z;
                n4_det = 32'(-r3_dir1);
            end
            ppi_pkg::PAIR_XY: begin
                n4_a = r3_w.plane_a_normal_x;  n4_b = r3_w.plane_a_normal_y;
                n4_c = r3_w.plane_b_normal_x;  n4_d = r3_w.plane_b_normal_y;
                n4_det = r3_dir2;
            end
            default: begin
                n4_a = r3_w.plane_a_normal_y;  n4_b = r3_w.plane_a_normal_z;
                n4_c = r3_w.plane_b_normal_y;  n4_d = r3_w.plane_b_normal_z;
                n4_det = r3_dir0;
            end
        endcase

        n6_nu   = 50'(r5_ad) - 50'(r5_bdb);
        n6_nv   = 50'(r5_adb) - 50'(r5_cda);
        n6_mu   = n6_nu[49] ? 49'(-n6_nu) : n6_nu[48:0];
        n6_mv   = n6_nv[49] ? 49'(-n6_nv) : n6_nv[48:0];
        n6_numu = {n6_mu, 8'd0};
        n6_numv = {n6_mv, 8'd0};
        n6_den  = r5_det[31] ? 31'(-r5_det) : r5_det[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_w   <= i_word;
            r1_pyz <= i_word.plane_a_normal_y * i_word.plane_b_normal_z;
            r1_pzy <= i_word.plane_a_normal_z * i_word.plane_b_normal_y;
            r1_pzx <= i_word.plane_a_normal_z * i_word.plane_b_normal_x;
            r1_pxz <= i_word.plane_a_normal_x * i_word.plane_b_normal_z;
            r1_pxy <= i_word.plane_a_normal_x * i_word.plane_b_normal_y;
            r1_pyx <= i_word.plane_a_normal_y * i_word.plane_b_normal_x;
            r1_ma0 <= i_word.plane_a_normal_x * i_word.plane_a_point_x;
            r1_ma1 <= i_word.plane_a_normal_y * i_word.plane_a_point_y;
            r1_ma2 <= i_word.plane_a_normal_z * i_word.plane_a_point_z;
            r1_mb0 <= i_word.plane_b_normal_x * i_word.plane_b_point_x;
            r1_mb1 <= i_word.plane_b_normal_y * i_word.plane_b_point_y;
            r1_mb2 <= i_word.plane_b_normal_z * i_word.plane_b_point_z;

            r2_w    <= r1_w;
            r2_dir0 <= n2_dir0[31:0];
            r2_dir1 <= n2_dir1[31:0];
            r2_dir2 <= n2_dir2[31:0];
            r2_da   <= 33'(r1_ma0) + 33'(r1_ma1) + 33'(r1_ma2);
            r2_db   <= 33'(r1_mb0) + 33'(r1_mb1) + 33'(r1_mb2);

            r3_w    <= r2_w;
            r3_dir0 <= r2_dir0;
            r3_dir1 <= r2_dir1;
            r3_dir2 <= r2_dir2;
            r3_da   <= r2_da;
            r3_db   <= r2_db;
            r3_ax   <= n3_ax;
            r3_ay   <= n3_ay;
            r3_az   <= n3_az;
            r3_sq0  <= n3_ax * n3_ax;
            r3_sq1  <= n3_ay * n3_ay;
            r3_sq2  <= n3_az * n3_az;
            r3_eps2 <= i_eps * i_eps;
            r3_fix  <= n3_fix;

            r4_dir0  <= r3_dir0;
            r4_dir1  <= r3_dir1;
            r4_dir2  <= r3_dir2;
            r4_da    <= r3_da;
            r4_db    <= r3_db;
            r4_found <= n4_len2 > 64'(r3_eps2);
            r4_pair  <= n4_pair;
            r4_a     <= n4_a;
            r4_b     <= n4_b;
            r4_c     <= n4_c;
            r4_d     <= n4_d;
            r4_det   <= n4_det;

            r5_ad    <= r4_da * r4_d;
            r5_bdb   <= r4_b * r4_db;
            r5_adb   <= r4_a * r4_db;
            r5_cda   <= r4_c * r4_da;
            r5_dir0  <= r4_dir0;
            r5_dir1  <= r4_dir1;
            r5_dir2  <= r4_dir2;
            r5_det   <= r4_det;
            r5_found <= r4_found;
            r5_pair  <= r4_pair;

            r6_word.mag_u      <= n6_numu;
            r6_word.mag_v      <= n6_numv;
            r6_word.den        <= n6_den;
            r6_word.side.found <= r5_found;
            r6_word.side.pair  <= r5_pair;
            r6_word.side.dir_x <= r5_dir0;
            r6_word.side.dir_y <= r5_dir1;
            r6_word.side.dir_z <= r5_dir2;
            r6_word.side.neg_u <= n6_nu[49] ^ r5_det[31];
            r6_word.side.neg_v <= n6_nv[49] ^ r5_det[31];
            r6_word.side.ovf_u <= 63'(n6_numu) >= {n6_den, 32'd0};
            r6_word.side.ovf_v <= 63'(n6_numv) >= {n6_den, 32'd0};
        end
    end

    assign o_valid = r_v[ppi_pkg::FRONT_STG-1];
    assign o_word  = r6_word;
endmodule
`default_nettype wire

@@ hdl/ppi_div.sv @@
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on ppi_pkg.
`default_nettype none
module ppi_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  ppi_pkg::t_div_in                 i_word,
    output logic                             o_valid,
    output logic [ppi_pkg::COORD_W-1:0]      o_q_u,
    output logic [ppi_pkg::COORD_W-1:0]      o_q_v,
    output ppi_pkg::t_side                   o_side
);
    localparam int N = ppi_pkg::DIV_STEPS;

    logic [N-1:0]              r_v;
    ppi_pkg::t_div_lane        r_u    [N];
    ppi_pkg::t_div_lane        r_l    [N];
    logic [ppi_pkg::MAG_W-1:0] r_den  [N];
    ppi_pkg::t_side            r_side [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_u[k]    <= ppi_pkg::div_step(ppi_pkg::div_load(i_word.mag_u), i_word.den);
                    r_l[k]    <= ppi_pkg::div_step(ppi_pkg::div_load(i_word.mag_v), i_word.den);
                    r_den[k]  <= i_word.den;
                    r_side[k] <= i_word.side;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_u[k]    <= ppi_pkg::div_step(r_u[k-1], r_den[k-1]);
                    r_l[k]    <= ppi_pkg::div_step(r_l[k-1], r_den[k-1]);
                    r_den[k]  <= r_den[k-1];
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_q_u   = r_u[N-1].low;
    assign o_q_v   = r_l[N-1].low;
    assign o_side  = r_side[N-1];
endmodule
`default_nettype wire

@@ hdl/plane_plane_intersection.sv @@
// Top level of the plane-plane intersection pipeline: config register, output stage.
// Depends on ppi_pkg, ppi_ifs, ppi_front and ppi_div.
// One word is taken every cycle while the result side keeps up; each word's result
// passes through six front stages, 32 divider stages and one output register. Both
// quotient lanes of the divider run 32 restoring steps. A stall
// on the result side freezes the whole pipeline, nothing is lost or repeated.
`default_nettype none
module plane_plane_intersection (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [ppi_pkg::EPS_W-1:0] i_cfg_wdata,
    ppi_in_if.sink                         i_in,
    ppi_out_if.source                      o_out
);
    logic [ppi_pkg::EPS_W-1:0] r_eps;
    logic                      r_ov;
    ppi_pkg::t_out_word        r_out;
    ppi_pkg::t_out_word        n_out;
    logic                      w_en;
    logic                      w_fv;
    ppi_pkg::t_div_in          w_fword;
    logic                      w_dv;
    logic [ppi_pkg::COORD_W-1:0] w_qu, w_qv, w_su, w_sv;
    ppi_pkg::t_side            w_side;

    assign w_en = !r_ov || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= ppi_pkg::EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    ppi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_word  (i_in.data),
        .i_eps   (r_eps),
        .o_valid (w_fv),
        .o_word  (w_fword)
    );

    ppi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_word  (w_fword),
        .o_valid (w_dv),
        .o_q_u   (w_qu),
        .o_q_v   (w_qv),
        .o_side  (w_side)
    );

    assign w_su = ppi_pkg::sat_q(w_qu, w_side.neg_u, w_side.ovf_u);
    assign w_sv = ppi_pkg::sat_q(w_qv, w_side.neg_v, w_side.ovf_v);

    always_comb begin
        n_out = '0;
        if (w_side.found) begin
            n_out.found      = 1'b1;
            n_out.line_dir_x = w_side.dir_x;
            n_out.line_dir_y = w_side.dir_y;
            n_out.line_dir_z = w_side.dir_z;
            case (w_side.pair)
                ppi_pkg::PAIR_YZ: begin
                    n_out.line_point_y = w_su;
                    n_out.line_point_z = w_sv;
                end
                ppi_pkg::PAIR_XZ: begin
                    n_out.line_point_x = w_su;
                    n_out.line_point_z = w_sv;
                end
                ppi_pkg::PAIR_XY: begin
                    n_out.line_point_x = w_su;
                    n_out.line_point_y = w_sv;
                end
                default: begin
                    n_out.line_point_x = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign i_in.ready = w_en;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

`ifndef ASSERT_OFF
    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.found) |->
        (o_out.data.line_dir_x == 0 && o_out.data.line_dir_y == 0 &&
         o_out.data.line_dir_z == 0 && o_out.data.line_point_x == 0))
        else $error("parallel result carries non-zero fields");
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (o_out.ready || !o_out.valid))
        else $error("input ready does not follow output stage");
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_cfg_we)) |-> r_eps == $past(i_cfg_wdata))
        else $error("threshold register missed a write");
`endif
endmodule
`default_nettype wire
